FILE: hw/rtl/apm_pkg.sv
// Shared types, constants and the microcode ROM for the attitude PID fin mixer.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps

package apm_pkg;

  localparam int STEP_W    = 4;
  localparam int AXIS_W    = 2;
  localparam int PROD_W    = 50;
  localparam int RND_W     = 51;
  localparam int ERR_W     = 18;
  localparam int INC_W     = 26;
  localparam int GAIN_W    = 48;
  localparam int ILIM_W    = 31;
  localparam int SLIM_W    = 15;
  localparam int CFG_AW    = 6;
  localparam int CFG_DW    = 64;
  localparam int NUM_AXES  = 3;

  localparam logic [AXIS_W-1:0] AXIS_LAST = AXIS_W'(NUM_AXES - 1);

  localparam logic signed [31:0] ERR_GAIN_NEG  = -32'sd117342;
  localparam int                 FIN_MID       = 23040;
  localparam int                 SERVO_MAX     = 23040;
  localparam logic [ILIM_W-1:0]  ILIM_RESET    = 31'd655360;
  localparam logic [SLIM_W-1:0]  SLIM_RESET    = 15'd7680;

  typedef struct packed {
    logic               action;
    logic signed [15:0] quat_x;
    logic signed [15:0] quat_y;
    logic signed [15:0] quat_z;
    logic signed [15:0] gyro_x;
    logic signed [15:0] gyro_y;
    logic signed [15:0] gyro_z;
    logic [15:0]        step_time;
  } in_item_t;

  typedef struct packed {
    logic [15:0] servo_top;
    logic [15:0] servo_right;
    logic [15:0] servo_bottom;
    logic [15:0] servo_left;
  } out_item_t;

  typedef enum logic [2:0] {
    REG_ROLL_GAINS  = 3'd0,
    REG_PITCH_GAINS = 3'd1,
    REG_YAW_GAINS   = 3'd2,
    REG_INTEG_LIMIT = 3'd3,
    REG_SERVO_LIMIT = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic [NUM_AXES-1:0][GAIN_W-1:0] gains;
    logic [ILIM_W-1:0]               integ_lim;
    logic [SLIM_W-1:0]               servo_lim;
  } cfg_regs_t;

  typedef enum logic [2:0] {
    MUL_NONE,
    MUL_ERRGAIN,
    MUL_DT,
    MUL_KP,
    MUL_KI,
    MUL_KD
  } mul_sel_t;

  typedef enum logic [2:0] {
    RND_NONE,
    RND_D,
    RND_ERR,
    RND_INC,
    RND_P,
    RND_I
  } rnd_sel_t;

  typedef enum logic [1:0] {
    JMP_NEXT,
    JMP_AXIS,
    JMP_EMIT
  } jmp_t;

  typedef struct packed {
    mul_sel_t          mul_sel;
    rnd_sel_t          rnd_sel;
    logic              integ_upd;
    logic              axis_sum;
    jmp_t              jmp;
    logic [STEP_W-1:0] target;
  } ucode_t;

  typedef struct packed {
    ucode_t            uw;
    logic [AXIS_W-1:0] axis;
    logic              load_in;
    logic              clear;
    logic              emit;
  } dp_ctrl_t;

  localparam ucode_t UCODE_NOP = '{MUL_NONE, RND_NONE, 1'b0, 1'b0, JMP_NEXT, '0};

  // one control word per step; steps 0..8 run once per axis, step 9 mixes and emits
  function automatic ucode_t ucode_rom(input logic [STEP_W-1:0] step);
    ucode_t w;
    w = UCODE_NOP;
    case (step)
      4'd0: w.mul_sel = MUL_KD;
      4'd1: begin
        w.mul_sel = MUL_ERRGAIN;
        w.rnd_sel = RND_D;
      end
      4'd2: w.rnd_sel = RND_ERR;
      4'd3: w.mul_sel = MUL_DT;
      4'd4: begin
        w.mul_sel = MUL_KP;
        w.rnd_sel = RND_INC;
      end
      4'd5: begin
        w.integ_upd = 1'b1;
        w.rnd_sel   = RND_P;
      end
      4'd6: w.mul_sel = MUL_KI;
      4'd7: w.rnd_sel = RND_I;
      4'd8: begin
        w.axis_sum = 1'b1;
        w.jmp      = JMP_AXIS;
        w.target   = STEP_W'(0);
      end
      4'd9: w.jmp = JMP_EMIT;
      default: w = UCODE_NOP;
    endcase
    return w;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [RND_W-1:0] v);
    if (v > RND_W'(32'sh7fffffff)) begin
      return 32'sh7fffffff;
    end else if (v < -(RND_W'(33'sh080000000))) begin
      return 32'sh80000000;
    end else begin
      return v[31:0];
    end
  endfunction

endpackage

FILE: hw/rtl/apm_cfg.sv
// APB-style register file for gains, integrator clamp and servo limit.
// Depends on apm_pkg for register indexes and the register bundle type.
`timescale 1ns / 1ps

module apm_cfg (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [apm_pkg::CFG_AW-1:0]  paddr,
  input  logic [apm_pkg::CFG_DW-1:0]  pwdata,
  output logic [apm_pkg::CFG_DW-1:0]  prdata,
  output logic                        pready,
  output apm_pkg::cfg_regs_t          regs
);
  import apm_pkg::*;

  cfg_regs_t regs_r, regs_nxt;
  reg_idx_t  idx;

  assign idx    = reg_idx_t'(paddr[CFG_AW-1:3]);
  assign pready = 1'b1;
  assign regs   = regs_r;

  always_comb begin
    regs_nxt = regs_r;
    if (psel && penable && pwrite) begin
      case (idx)
        REG_ROLL_GAINS:  regs_nxt.gains[0]  = pwdata[GAIN_W-1:0];
        REG_PITCH_GAINS: regs_nxt.gains[1]  = pwdata[GAIN_W-1:0];
        REG_YAW_GAINS:   regs_nxt.gains[2]  = pwdata[GAIN_W-1:0];
        REG_INTEG_LIMIT: regs_nxt.integ_lim = pwdata[ILIM_W-1:0];
        REG_SERVO_LIMIT: regs_nxt.servo_lim = pwdata[SLIM_W-1:0];
        default: regs_nxt = regs_r;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_ROLL_GAINS:  prdata = CFG_DW'(regs_r.gains[0]);
      REG_PITCH_GAINS: prdata = CFG_DW'(regs_r.gains[1]);
      REG_YAW_GAINS:   prdata = CFG_DW'(regs_r.gains[2]);
      REG_INTEG_LIMIT: prdata = CFG_DW'(regs_r.integ_lim);
      REG_SERVO_LIMIT: prdata = CFG_DW'(regs_r.servo_lim);
      default:         prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r.gains     <= '0;
      regs_r.integ_lim <= ILIM_RESET;
      regs_r.servo_lim <= SLIM_RESET;
    end else begin
      regs_r <= regs_nxt;
    end
  end

endmodule

FILE: hw/rtl/apm_seq.sv
// Microcode sequencer: step counter, axis loop counter, ROM lookup and handshakes.
// Depends on apm_pkg for the control word, the ROM function and the control bundle.
`timescale 1ns / 1ps

module apm_seq (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_action,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output apm_pkg::dp_ctrl_t ctrl
);
  import apm_pkg::*;

  logic              busy_r, busy_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic [AXIS_W-1:0] axis_r, axis_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              accept;
  ucode_t            uw;

  assign in_ready  = !busy_r;
  assign out_valid = out_valid_r;
  assign accept    = in_valid && in_ready;
  assign uw        = busy_r ? ucode_rom(step_r) : UCODE_NOP;

  always_comb begin
    busy_nxt      = busy_r;
    step_nxt      = step_r;
    axis_nxt      = axis_r;
    out_valid_nxt = out_valid_r && !out_ready;
    ctrl.uw       = uw;
    ctrl.axis     = axis_r;
    ctrl.load_in  = accept;
    ctrl.clear    = accept && in_action;
    ctrl.emit     = 1'b0;
    if (accept && !in_action) begin
      busy_nxt = 1'b1;
      step_nxt = '0;
      axis_nxt = '0;
    end else if (busy_r) begin
      case (uw.jmp)
        JMP_NEXT: step_nxt = step_r + STEP_W'(1);
        JMP_AXIS: begin
          if (axis_r != AXIS_LAST) begin
            axis_nxt = axis_r + AXIS_W'(1);
            step_nxt = uw.target;
          end else begin
            step_nxt = step_r + STEP_W'(1);
          end
        end
        JMP_EMIT: begin
          // hold until the output register is free
          if (!out_valid_r || out_ready) begin
            ctrl.emit     = 1'b1;
            out_valid_nxt = 1'b1;
            busy_nxt      = 1'b0;
          end
        end
        default: step_nxt = step_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      step_r      <= '0;
      axis_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      step_r      <= step_nxt;
      axis_r      <= axis_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

FILE: hw/rtl/apm_dp.sv
// Datapath: shared multiplier, rounding and saturation unit, integrators and fin mixer.
// Depends on apm_pkg; driven by the control bundle from apm_seq.
`timescale 1ns / 1ps

module apm_dp (
  input  logic               clk,
  input  logic               rst_n,
  input  apm_pkg::dp_ctrl_t  ctrl,
  input  apm_pkg::in_item_t  in_data,
  input  apm_pkg::cfg_regs_t regs,
  output apm_pkg::out_item_t out_data
);
  import apm_pkg::*;

  in_item_t                  item_r;
  logic signed [PROD_W-1:0]  prod_r, prod_nxt;
  logic signed [ERR_W-1:0]   err_r;
  logic signed [INC_W-1:0]   inc_r;
  logic signed [31:0]        p_r, i_r, d_r;
  logic signed [31:0]        integ_r [NUM_AXES];
  logic signed [31:0]        axis_out_r [NUM_AXES];
  out_item_t                 out_r;

  logic signed [GAIN_W-1:0]  gains;
  logic signed [15:0]        quat, gyro;
  logic signed [ERR_W-1:0]   mul_a;
  logic signed [31:0]        mul_b;
  logic signed [RND_W-1:0]   rnd_ext, rnd_sh;
  logic signed [31:0]        rnd_sat;
  logic signed [32:0]        integ_sum, ilim, integ_new;
  logic signed [RND_W-1:0]   pid_sum;
  logic [SLIM_W-1:0]         slim;
  out_item_t                 mix;

  function automatic logic [15:0] fin_cmd(input logic signed [32:0] m,
                                          input logic [SLIM_W-1:0] lim);
    logic signed [32:0] l;
    logic signed [32:0] c;
    l = $signed({18'b0, lim});
    if (m > l) begin
      c = l;
    end else if (m < -l) begin
      c = -l;
    end else begin
      c = m;
    end
    return 16'(c + 33'(FIN_MID));
  endfunction

  assign out_data = out_r;

  always_comb begin
    gains = $signed(regs.gains[ctrl.axis]);
    case (ctrl.axis)
      2'd0: begin
        quat = item_r.quat_x;
        gyro = item_r.gyro_x;
      end
      2'd1: begin
        quat = item_r.quat_y;
        gyro = item_r.gyro_y;
      end
      default: begin
        quat = item_r.quat_z;
        gyro = item_r.gyro_z;
      end
    endcase
  end

  // shared multiplier, at most one product per step
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (ctrl.uw.mul_sel)
      MUL_ERRGAIN: begin
        mul_a = ERR_W'(quat);
        mul_b = ERR_GAIN_NEG;
      end
      MUL_DT: begin
        mul_a = err_r;
        mul_b = $signed({16'b0, item_r.step_time});
      end
      MUL_KP: begin
        mul_a = ERR_W'($signed(gains[15:0]));
        mul_b = 32'(err_r);
      end
      MUL_KI: begin
        mul_a = ERR_W'($signed(gains[31:16]));
        mul_b = integ_r[ctrl.axis];
      end
      MUL_KD: begin
        mul_a = ERR_W'($signed(gains[47:32]));
        mul_b = 32'(gyro);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    prod_nxt = mul_a * mul_b;
  end

  // round to nearest, ties up, then saturate
  always_comb begin
    rnd_ext = RND_W'(prod_r);
    case (ctrl.uw.rnd_sel)
      RND_D:          rnd_sh = (rnd_ext + RND_W'(8)) >>> 4;
      RND_INC, RND_P: rnd_sh = (rnd_ext + RND_W'(128)) >>> 8;
      RND_ERR, RND_I: rnd_sh = (rnd_ext + RND_W'(32768)) >>> 16;
      default:        rnd_sh = rnd_ext;
    endcase
    rnd_sat = sat32(rnd_sh);
  end

  always_comb begin
    integ_sum = 33'(integ_r[ctrl.axis]) + 33'(inc_r);
    ilim      = $signed({2'b0, regs.integ_lim});
    if (integ_sum > ilim) begin
      integ_new = ilim;
    end else if (integ_sum < -ilim) begin
      integ_new = -ilim;
    end else begin
      integ_new = integ_sum;
    end
    pid_sum = RND_W'(p_r) + RND_W'(i_r) - RND_W'(d_r);
  end

  // plus mixer: roll, pitch, yaw in axis order
  always_comb begin
    slim = (regs.servo_lim > SLIM_W'(SERVO_MAX)) ? SLIM_W'(SERVO_MAX) : regs.servo_lim;
    mix.servo_top    = fin_cmd(33'(axis_out_r[1]) + 33'(axis_out_r[0]), slim);
    mix.servo_right  = fin_cmd(33'(axis_out_r[2]) + 33'(axis_out_r[0]), slim);
    mix.servo_bottom = fin_cmd(33'(axis_out_r[0]) - 33'(axis_out_r[1]), slim);
    mix.servo_left   = fin_cmd(33'(axis_out_r[0]) - 33'(axis_out_r[2]), slim);
  end

  always_ff @(posedge clk) begin
    if (ctrl.load_in) begin
      item_r <= in_data;
    end
    if (ctrl.uw.mul_sel != MUL_NONE) begin
      prod_r <= prod_nxt;
    end
    case (ctrl.uw.rnd_sel)
      RND_D:   d_r   <= rnd_sat;
      RND_ERR: err_r <= rnd_sh[ERR_W-1:0];
      RND_INC: inc_r <= rnd_sh[INC_W-1:0];
      RND_P:   p_r   <= rnd_sat;
      RND_I:   i_r   <= rnd_sat;
      default: ;
    endcase
    if (ctrl.uw.axis_sum) begin
      axis_out_r[ctrl.axis] <= sat32(pid_sum);
    end
    if (ctrl.emit) begin
      out_r <= mix;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int a = 0; a < NUM_AXES; a++) begin
        integ_r[a] <= '0;
      end
    end else if (ctrl.clear) begin
      for (int a = 0; a < NUM_AXES; a++) begin
        integ_r[a] <= '0;
      end
    end else if (ctrl.uw.integ_upd) begin
      integ_r[ctrl.axis] <= integ_new[31:0];
    end
  end

endmodule

FILE: hw/rtl/attitude_pid_fin_mixer.sv
// Top level of the three-axis attitude PID with plus-configuration fin mixer.
// Depends on apm_pkg, apm_cfg, apm_seq and apm_dp.
`timescale 1ns / 1ps

// A control update item is taken when the block is free and a new one is not taken
// until its fin commands have been loaded into the output register; the pace is set by
// the single shared 18x32 multiplier, stepped by a ten-word microprogram that runs
// nine steps for each of the three axes and one step to mix and load the output.
// A clear item zeroes the integrators and produces no result. The output register
// holds a finished result while the next item is being worked on; only the final
// mixing step waits for it to be taken. Registers sit at byte address 8*index on
// the 64-bit configuration port and should be written while idle.
module attitude_pid_fin_mixer (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  apm_pkg::in_item_t          in_data,
  output logic                       out_valid,
  input  logic                       out_ready,
  output apm_pkg::out_item_t         out_data,
  input  logic                       cfg_psel,
  input  logic                       cfg_penable,
  input  logic                       cfg_pwrite,
  input  logic [apm_pkg::CFG_AW-1:0] cfg_paddr,
  input  logic [apm_pkg::CFG_DW-1:0] cfg_pwdata,
  output logic [apm_pkg::CFG_DW-1:0] cfg_prdata,
  output logic                       cfg_pready
);
  import apm_pkg::*;

  cfg_regs_t regs;
  dp_ctrl_t  ctrl;

  apm_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .regs    (regs)
  );

  apm_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_action (in_data.action),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .ctrl      (ctrl)
  );

  apm_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctrl     (ctrl),
    .in_data  (in_data),
    .regs     (regs),
    .out_data (out_data)
  );

endmodule

FILE: tb/sv/testbench.sv
// Self-checking testbench for attitude_pid_fin_mixer: drives update and clear items,
// writes the gain and limit registers over the APB port and checks every fin command.
// Depends on apm_pkg and the attitude_pid_fin_mixer RTL.
`timescale 1ns / 1ps

module testbench;
  import apm_pkg::*;

  localparam int CYCLE_LIMIT   = 1000000;
  localparam int SETTLE_CYCLES = 40;
  localparam int NUM_REGS      = 5;
  localparam int LAST_REG_SLOT = (2 ** CFG_AW) / 8 - 1;
  localparam int RECONFIG_GAP  = 70;

  logic               clk       = 1'b0;
  logic               rst_n     = 1'b0;
  logic               in_valid  = 1'b0;
  logic               in_ready;
  in_item_t           in_data   = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  out_item_t          out_data;
  logic               psel      = 1'b0;
  logic               penable   = 1'b0;
  logic               pwrite    = 1'b0;
  logic [CFG_AW-1:0]  paddr     = '0;
  logic [CFG_DW-1:0]  pwdata    = '0;
  logic [CFG_DW-1:0]  prdata;
  logic               pready;

  // predictor state
  logic [GAIN_W-1:0]  gain_reg [NUM_AXES];
  logic [ILIM_W-1:0]  integ_lim = ILIM_RESET;
  logic [SLIM_W-1:0]  servo_lim = SLIM_RESET;
  int                 integ_acc [NUM_AXES];
  out_item_t          pending_fins [$];

  int send_idle_pct   = 0;
  int ready_stall_pct = 0;
  int fail_count      = 0;
  int cycle_count     = 0;
  int n_updates       = 0;
  int n_clears        = 0;
  int n_writes        = 0;
  int n_fins          = 0;

  attitude_pid_fin_mixer dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .cfg_psel    (psel),
    .cfg_penable (penable),
    .cfg_pwrite  (pwrite),
    .cfg_paddr   (paddr),
    .cfg_pwdata  (pwdata),
    .cfg_prdata  (prdata),
    .cfg_pready  (pready)
  );

  always #1 clk = ~clk;

  always_ff @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= ready_stall_pct);
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) @(posedge clk);
    $display("TEST FAILED");
    $finish;
  end

  function automatic longint round_shift(longint v, int n);
    return (v + (longint'(1) <<< (n - 1))) >>> n;
  endfunction

  function automatic longint sat_word(longint v);
    if (v > 64'sd2147483647) begin
      return 64'sd2147483647;
    end
    if (v < -64'sd2147483648) begin
      return -64'sd2147483648;
    end
    return v;
  endfunction

  function automatic longint pid_axis(int axis, logic [15:0] q, logic [15:0] g,
                                      logic [15:0] dt);
    longint qs, gs, kp, ki, kd, err, acc, lim;
    qs  = longint'($signed(q));
    gs  = longint'($signed(g));
    kp  = longint'($signed(gain_reg[axis][15:0]));
    ki  = longint'($signed(gain_reg[axis][31:16]));
    kd  = longint'($signed(gain_reg[axis][47:32]));
    lim = longint'(integ_lim);
    err = round_shift(qs * longint'(ERR_GAIN_NEG), 16);
    acc = longint'(integ_acc[axis]) + round_shift(err * longint'(dt), 8);
    if (acc > lim) begin
      acc = lim;
    end else if (acc < -lim) begin
      acc = -lim;
    end
    integ_acc[axis] = int'(acc);
    return sat_word(sat_word(round_shift(kp * err, 8)) + sat_word(round_shift(ki * acc, 16))
                    - sat_word(round_shift(kd * gs, 4)));
  endfunction

  function automatic logic [15:0] fin_angle(longint mix);
    longint lim;
    lim = (servo_lim > SERVO_MAX) ? longint'(SERVO_MAX) : longint'(servo_lim);
    if (mix > lim) begin
      mix = lim;
    end else if (mix < -lim) begin
      mix = -lim;
    end
    return 16'(longint'(FIN_MID) + mix);
  endfunction

  function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin : fin_check
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      n_fins++;
      if (pending_fins.size() == 0) begin
        $error("fin command item with none outstanding: %h", out_data);
        fail_count++;
      end else begin
        want = pending_fins.pop_front();
        check_field("servo_top", want.servo_top, out_data.servo_top);
        check_field("servo_right", want.servo_right, out_data.servo_right);
        check_field("servo_bottom", want.servo_bottom, out_data.servo_bottom);
        check_field("servo_left", want.servo_left, out_data.servo_left);
      end
    end
  end

  task automatic send_item(in_item_t it);
    longint    roll, pitch, yaw;
    out_item_t fins;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
    if (it.action) begin
      n_clears++;
      foreach (integ_acc[a]) integ_acc[a] = 0;
    end else begin
      n_updates++;
      roll  = pid_axis(REG_ROLL_GAINS, it.quat_x, it.gyro_x, it.step_time);
      pitch = pid_axis(REG_PITCH_GAINS, it.quat_y, it.gyro_y, it.step_time);
      yaw   = pid_axis(REG_YAW_GAINS, it.quat_z, it.gyro_z, it.step_time);
      fins.servo_top    = fin_angle(pitch + roll);
      fins.servo_right  = fin_angle(yaw + roll);
      fins.servo_bottom = fin_angle(roll - pitch);
      fins.servo_left   = fin_angle(roll - yaw);
      pending_fins.push_back(fins);
    end
  endtask

  task automatic drain_and_settle();
    in_valid <= 1'b0;
    while (pending_fins.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(int idx, logic [CFG_DW-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CFG_AW'(idx * 8);
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    n_writes++;
    case (idx)
      REG_ROLL_GAINS, REG_PITCH_GAINS, REG_YAW_GAINS: gain_reg[idx] = value[GAIN_W-1:0];
      REG_INTEG_LIMIT: integ_lim = value[ILIM_W-1:0];
      REG_SERVO_LIMIT: servo_lim = value[SLIM_W-1:0];
      default: ;
    endcase
  endtask

  function automatic in_item_t update_item(logic [15:0] qx, logic [15:0] qy, logic [15:0] qz,
                                           logic [15:0] gx, logic [15:0] gy, logic [15:0] gz,
                                           logic [15:0] dt);
    in_item_t it;
    it.action    = 1'b0;
    it.quat_x    = qx;
    it.quat_y    = qy;
    it.quat_z    = qz;
    it.gyro_x    = gx;
    it.gyro_y    = gy;
    it.gyro_z    = gz;
    it.step_time = dt;
    return it;
  endfunction

  function automatic logic [15:0] pick_gain();
    case ($urandom_range(9))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'($urandom);
      3: return 16'($urandom_range(128)) - 16'd64;
      default: return 16'($urandom_range(768)) - 16'd384;
    endcase
  endfunction

  function automatic logic [15:0] pick_quat();
    case ($urandom_range(9))
      0: return 16'($urandom);
      1, 2: return 16'($urandom_range(1024)) - 16'd512;
      default: return 16'($urandom_range(32768)) - 16'd16384;
    endcase
  endfunction

  function automatic logic [15:0] pick_rate();
    if ($urandom_range(9) < 3) begin
      return 16'($urandom);
    end
    return 16'($urandom_range(4096)) - 16'd2048;
  endfunction

  function automatic logic [15:0] pick_step();
    case ($urandom_range(19))
      0: return 16'd0;
      1, 2, 3: return 16'($urandom);
      default: return 16'($urandom_range(700, 1));
    endcase
  endfunction

  function automatic in_item_t random_item();
    in_item_t it;
    it = update_item(pick_quat(), pick_quat(), pick_quat(), pick_rate(), pick_rate(),
                     pick_rate(), pick_step());
    it.action = ($urandom_range(99) < 8);
    return it;
  endfunction

  task automatic load_random_settings();
    logic [CFG_DW-1:0] lim;
    for (int r = REG_ROLL_GAINS; r <= REG_YAW_GAINS; r++) begin
      cfg_write(r, {16'($urandom), pick_gain(), pick_gain(), pick_gain()});
    end
    case ($urandom_range(4))
      0: lim = '0;
      1: lim = 64'h7fffffff;
      2: lim = 64'($urandom);
      default: lim = 64'($urandom_range(1 << 22, 1 << 16));
    endcase
    cfg_write(REG_INTEG_LIMIT, lim);
    case ($urandom_range(5))
      0: lim = '0;
      1: lim = 64'(SERVO_MAX);
      2: lim = 64'h7fff;
      3: lim = 64'($urandom);
      default: lim = 64'($urandom_range(SERVO_MAX));
    endcase
    cfg_write(REG_SERVO_LIMIT, lim);
  endtask

  // zero gains after reset: every fin sits at centre whatever the input
  task automatic test_reset_state();
    send_item(update_item(16'sd16384, 16'hc000, 16'h7fff, 16'h7fff, 16'h8000, 16'h0001,
                          16'hffff));
    send_item(update_item(16'h8000, 16'sd0, 16'sd16384, 16'h8000, 16'h7fff, 16'hffff,
                          16'd1));
    drain_and_settle();
  endtask

  task automatic test_fixed_cases();
    cfg_write(REG_ROLL_GAINS, {16'h0, 16'h0010, 16'h0080, 16'h0100});
    cfg_write(REG_PITCH_GAINS, {16'h0, 16'hfff0, 16'h0040, 16'h0080});
    cfg_write(REG_YAW_GAINS, {16'h0, 16'h0008, 16'hffc0, 16'hff00});
    cfg_write(REG_INTEG_LIMIT, 64'd327680);
    cfg_write(REG_SERVO_LIMIT, 64'd7680);
    send_item(update_item(16'sd16384, 16'sd16384, 16'sd16384, 16'sd0, 16'sd0, 16'sd0,
                          16'd655));
    send_item(update_item(16'hc000, 16'hc000, 16'hc000, 16'sd0, 16'sd0, 16'sd0, 16'd655));
    send_item(update_item(16'sd0, 16'sd0, 16'sd0, 16'h7fff, 16'h8000, 16'h7fff, 16'd1));
    send_item(update_item(16'h8000, 16'h7fff, 16'h8000, 16'h8000, 16'h7fff, 16'h8000,
                          16'd100));
    // hold a large error until the integrators clamp
    repeat (4) send_item(update_item(16'hc000, 16'sd16384, 16'h2000, 16'sd16, 16'sd32,
                                     16'hfff0, 16'hffff));
    send_item(update_item(16'sd200, 16'hff38, 16'sd10, 16'sd5, 16'sd5, 16'sd5, 16'd0));
    send_item('{action: 1'b1, quat_x: 16'hffff, quat_y: 16'hffff, quat_z: 16'hffff,
                gyro_x: 16'hffff, gyro_y: 16'hffff, gyro_z: 16'hffff, step_time: 16'hffff});
    send_item(update_item(16'sd100, 16'sd100, 16'sd100, 16'sd0, 16'sd0, 16'sd0, 16'd0));
    send_item('{action: 1'b1, default: '0});
    send_item(update_item(16'h0001, 16'hffff, 16'h0001, 16'h0001, 16'hffff, 16'h0001,
                          16'd65));
    drain_and_settle();
  endtask

  task automatic test_extreme_settings();
    cfg_write(REG_ROLL_GAINS, {16'h0, 16'h7fff, 16'h7fff, 16'h7fff});
    cfg_write(REG_PITCH_GAINS, {16'hffff, 16'h8000, 16'h8000, 16'h8000});
    cfg_write(REG_YAW_GAINS, {16'h0, 16'h8000, 16'h7fff, 16'h8000});
    cfg_write(REG_INTEG_LIMIT, 64'h7fffffff);
    cfg_write(REG_SERVO_LIMIT, 64'h7fff);
    send_item(update_item(16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff,
                          16'hffff));
    send_item(update_item(16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000,
                          16'hffff));
    send_item(update_item(16'sd4, 16'hfffc, 16'sd0, 16'sd1, 16'hffff, 16'sd0, 16'd1));
    drain_and_settle();
    cfg_write(REG_SERVO_LIMIT, 64'd0);
    cfg_write(REG_INTEG_LIMIT, 64'd0);
    send_item(update_item(16'hc000, 16'sd16384, 16'h8000, 16'h7fff, 16'h8000, 16'sd3,
                          16'hffff));
    drain_and_settle();
  endtask

  // writes to unused slots must leave the live settings alone
  task automatic test_spare_registers();
    cfg_write(REG_SERVO_LIMIT, 64'(SERVO_MAX));
    for (int r = NUM_REGS; r <= LAST_REG_SLOT; r++) begin
      cfg_write(r, {$urandom, $urandom});
      cfg_write(r, '1);
    end
    send_item(update_item(16'sd3000, 16'hf000, 16'sd500, 16'sd100, 16'hff00, 16'sd7,
                          16'd300));
    send_item(update_item(16'hfc00, 16'sd2000, 16'hff00, 16'hffe0, 16'sd40, 16'sd900,
                          16'd300));
    drain_and_settle();
  endtask

  task automatic test_traffic(int idle_pct, int stall_pct, int n);
    send_idle_pct   = idle_pct;
    ready_stall_pct = stall_pct;
    for (int i = 0; i < n; i++) begin
      if (i % RECONFIG_GAP == 0) begin
        drain_and_settle();
        load_random_settings();
      end
      send_item(random_item());
    end
    drain_and_settle();
  endtask

  initial begin
    foreach (gain_reg[a]) gain_reg[a] = '0;
    foreach (integ_acc[a]) integ_acc[a] = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_state();
    test_fixed_cases();
    test_extreme_settings();
    test_spare_registers();
    test_traffic(0, 0, 280);
    test_traffic(87, 0, 280);
    test_traffic(0, 87, 280);
    test_traffic(26, 26, 290);
    $display("Ran %0d control updates and %0d integrator clears, %0d fin commands checked,",
             n_updates, n_clears, n_fins);
    $display("%0d register writes incl. spare slots, under four sender/receiver pacing mixes.",
             n_writes);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
